// File: design/rtwa_pkg.sv
// ----------------------------------------------------------------------------
// rtwa_pkg
// Shared types, register codes, constants and helpers for the room thermostat
// with averaging.
// ----------------------------------------------------------------------------
package rtwa_pkg;

    localparam int TEMP_W  = 16;
    localparam int SUM_W   = 21;   // floor quotient of the running sum
    localparam int QS_W    = 17;   // per-sample floor quotient
    localparam int REM_W   = 4;    // remainder, average length is at most 16
    localparam int CNT_W   = 4;    // samples gathered, at most 15
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;

    localparam logic signed [TEMP_W-1:0] REJECT_FLOOR = -16'sd700;
    localparam logic [REM_W-1:0]         ROUND_LIMIT  = 4'd5;
    localparam logic signed [TEMP_W-1:0] AVG_RESET    = 16'sd225;

    typedef enum logic [1:0] {
        MODE_SAMPLE   = 2'd0,
        MODE_EXTERNAL = 2'd1,
        MODE_CONTROL  = 2'd2,
        MODE_FORCE    = 2'd3
    } mode_t;

    localparam logic [IDX_W-1:0] REG_HOUR_SCHEDULE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_SETPOINT_ZERO    = 3'd1;
    localparam logic [IDX_W-1:0] REG_SETPOINT_ONE     = 3'd2;
    localparam logic [IDX_W-1:0] REG_HYSTERESIS       = 3'd3;
    localparam logic [IDX_W-1:0] REG_CORRECTION       = 3'd4;
    localparam logic [IDX_W-1:0] REG_INVERT_OUTPUT    = 3'd5;
    localparam logic [IDX_W-1:0] REG_BOILER_CONTROL   = 3'd6;
    localparam logic [IDX_W-1:0] REG_EXTERNAL_TIMEOUT = 3'd7;

    typedef struct packed {
        logic [23:0]        hour_schedule;
        logic [8:0]         setpoint_zero;
        logic [8:0]         setpoint_one;
        logic [7:0]         hysteresis;
        logic signed [7:0]  correction;
        logic               invert_output;
        logic               boiler_control;
        logic [31:0]        external_timeout;
    } cfg_t;

    // Item after the input register: sample already checked, corrected and split
    // into floor quotient and remainder by the average length.
    typedef struct packed {
        mode_t                     mode;
        logic                      sample_ok;
        logic signed [TEMP_W-1:0]  sample;
        logic signed [QS_W-1:0]    sample_q;
        logic [REM_W-1:0]          sample_r;
        logic signed [TEMP_W-1:0]  temperature;
        logic                      sp_sel;
        logic [31:0]               now_ms;
    } prep_t;

    function automatic logic signed [TEMP_W-1:0] sat16(input logic signed [21:0] v);
        logic signed [TEMP_W-1:0] r;
        if (v > 22'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -22'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[TEMP_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/rtwa_if.sv
// ----------------------------------------------------------------------------
// rtwa_if
// Valid/ready channels for thermostat requests and results.
// ----------------------------------------------------------------------------
interface rtwa_in_if;
    import rtwa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                mode;
    logic signed [TEMP_W-1:0]  temperature;
    logic                      sample_valid;
    logic [4:0]                hour;
    logic                      force_select;
    logic [31:0]               now_ms;

    modport source (output valid, mode, temperature, sample_valid, hour, force_select,
                    now_ms, input ready);
    modport sink   (input valid, mode, temperature, sample_valid, hour, force_select,
                    now_ms, output ready);
endinterface

interface rtwa_out_if;
    import rtwa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [TEMP_W-1:0]  measured_temp;
    logic                      heater_pin;
    logic                      heat_reported;
    logic                      forced_active;
    logic                      force_accepted;
    logic [7:0]                reject_total;

    modport source (output valid, measured_temp, heater_pin, heat_reported, forced_active,
                    force_accepted, reject_total, input ready);
    modport sink   (input valid, measured_temp, heater_pin, heat_reported, forced_active,
                    force_accepted, reject_total, output ready);
endinterface

// File: design/room_thermostat_with_averaging_core.sv
// ----------------------------------------------------------------------------
// room_thermostat_with_averaging_core
// Room thermostat: sample averaging, external reading and hysteresis control.
// ----------------------------------------------------------------------------
// Usage:
//   item   - request channel; mode picks sensor sample, external reading,
//            control step or force request.
//   result - one result per request: averaged reading, heater pin, reported
//            demand, forced flag, force outcome and rejected-sample count.
//   cfg_we/cfg_index/cfg_data - register writes, taken at once; write only
//            while no request is in flight.
// A request passes the input register (sample check, correction, split by
// the average length) and then the state update that loads the result
// register. Throughput is one request per cycle while the receiver takes
// results; the state update is a single pass with no iteration.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; ready drops only when both hold.
// Reset returns registers to their defaults, the reading to 22.5 degrees,
// demand off with the pin high, and empties both stages.
// ----------------------------------------------------------------------------
module room_thermostat_with_averaging_core #(
    parameter int AVERAGE_LENGTH = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rtwa_in_if.sink                     item,
    rtwa_out_if.source                  result,
    input  logic                        cfg_we,
    input  logic [rtwa_pkg::IDX_W-1:0]  cfg_index,
    input  logic [rtwa_pkg::DATA_W-1:0] cfg_data
);
    import rtwa_pkg::*;

    cfg_t  cfg;
    logic  prep_valid;
    prep_t prep;
    logic  advance;

    rtwa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rtwa_prep #(
        .AVERAGE_LENGTH (AVERAGE_LENGTH)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .advance    (advance),
        .prep_valid (prep_valid),
        .prep       (prep)
    );

    rtwa_core #(
        .AVERAGE_LENGTH (AVERAGE_LENGTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .prep_valid (prep_valid),
        .prep       (prep),
        .advance    (advance),
        .result     (result)
    );

endmodule

// File: design/rtwa_cfg.sv
// ----------------------------------------------------------------------------
// rtwa_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module rtwa_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rtwa_pkg::IDX_W-1:0]  cfg_index,
    input  logic [rtwa_pkg::DATA_W-1:0] cfg_data,
    output rtwa_pkg::cfg_t              cfg
);
    import rtwa_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hour_schedule    <= 24'd4194240;
            cfg_reg.setpoint_zero    <= 9'd180;
            cfg_reg.setpoint_one     <= 9'd210;
            cfg_reg.hysteresis       <= 8'd4;
            cfg_reg.correction       <= 8'sd0;
            cfg_reg.invert_output    <= 1'b0;
            cfg_reg.boiler_control   <= 1'b1;
            cfg_reg.external_timeout <= 32'd600000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HOUR_SCHEDULE:    cfg_reg.hour_schedule    <= cfg_data[23:0];
                REG_SETPOINT_ZERO:    cfg_reg.setpoint_zero    <= cfg_data[8:0];
                REG_SETPOINT_ONE:     cfg_reg.setpoint_one     <= cfg_data[8:0];
                REG_HYSTERESIS:       cfg_reg.hysteresis       <= cfg_data[7:0];
                REG_CORRECTION:       cfg_reg.correction       <= $signed(cfg_data[7:0]);
                REG_INVERT_OUTPUT:    cfg_reg.invert_output    <= cfg_data[0];
                REG_BOILER_CONTROL:   cfg_reg.boiler_control   <= cfg_data[0];
                REG_EXTERNAL_TIMEOUT: cfg_reg.external_timeout <= cfg_data[31:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/rtwa_prep.sv
// ----------------------------------------------------------------------------
// rtwa_prep
// Input register: checks and corrects a sample, splits it by the average
// length and resolves the setpoint select.
// ----------------------------------------------------------------------------
module rtwa_prep #(
    parameter int AVERAGE_LENGTH = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    rtwa_in_if.sink         item,
    input  rtwa_pkg::cfg_t  cfg,
    input  logic            advance,
    output logic            prep_valid,
    output rtwa_pkg::prep_t prep
);
    import rtwa_pkg::*;

    localparam int U_W    = 17;
    localparam int SHIFT  = U_W + $clog2(AVERAGE_LENGTH);
    localparam int MULT   = ((1 << SHIFT) + AVERAGE_LENGTH - 1) / AVERAGE_LENGTH;
    localparam int PROD_W = U_W + SHIFT + 1;
    // Bias a multiple of the length so the split works on unsigned values.
    localparam int BIAS   = AVERAGE_LENGTH * ((32768 + AVERAGE_LENGTH - 1) / AVERAGE_LENGTH);
    localparam int BIAS_Q = BIAS / AVERAGE_LENGTH;

    logic                     valid_reg;
    prep_t                    data_reg;
    prep_t                    data_next;

    logic signed [16:0]       corr_sum;
    logic signed [TEMP_W-1:0] sample;
    logic [U_W-1:0]           biased;
    logic [PROD_W-1:0]        prod;
    logic [U_W-1:0]           quot;
    logic [U_W-1:0]           rem;
    logic [23:0]              sched_shift;

    assign item.ready = !valid_reg || advance;

    always_comb
    begin
        corr_sum    = {item.temperature[15], item.temperature}
                    + {{9{cfg.correction[7]}}, cfg.correction};
        sample      = sat16({{5{corr_sum[16]}}, corr_sum});
        biased      = {sample[15], sample} + U_W'(BIAS);
        prod        = PROD_W'(biased) * PROD_W'(MULT);
        quot        = prod[SHIFT +: U_W];
        rem         = biased - U_W'(quot * U_W'(AVERAGE_LENGTH));
        sched_shift = cfg.hour_schedule >> item.hour;

        data_next.mode        = mode_t'(item.mode);
        data_next.sample_ok   = item.sample_valid && (item.temperature != 16'sd0)
                              && (item.temperature >= REJECT_FLOOR);
        data_next.sample      = sample;
        data_next.sample_q    = $signed(quot - U_W'(BIAS_Q));
        data_next.sample_r    = rem[REM_W-1:0];
        data_next.temperature = item.temperature;
        data_next.sp_sel      = (mode_t'(item.mode) == MODE_FORCE) ? item.force_select
                                                                   : sched_shift[0];
        data_next.now_ms      = item.now_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            data_reg <= data_next;
        end
    end

    assign prep_valid = valid_reg;
    assign prep       = data_reg;

endmodule

// File: design/rtwa_core.sv
// ----------------------------------------------------------------------------
// rtwa_core
// Thermostat state, averaging, hysteresis control and the result register.
// ----------------------------------------------------------------------------
module rtwa_core #(
    parameter int AVERAGE_LENGTH = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rtwa_pkg::cfg_t  cfg,
    input  logic            prep_valid,
    input  rtwa_pkg::prep_t prep,
    output logic            advance,
    rtwa_out_if.source      result
);
    import rtwa_pkg::*;

    logic                     fire;

    logic signed [TEMP_W-1:0] avg_reg,        avg_next;
    logic signed [SUM_W-1:0]  quot_reg,       quot_next;
    logic [REM_W-1:0]         rem_reg,        rem_next;
    logic [CNT_W-1:0]         cnt_reg,        cnt_next;
    logic                     first_reg,      first_next;
    logic signed [TEMP_W-1:0] ext_temp_reg,   ext_temp_next;
    logic [31:0]              ext_stamp_reg,  ext_stamp_next;
    logic                     ext_fresh_reg,  ext_fresh_next;
    logic                     no_demand_reg,  no_demand_next;
    logic                     forced_reg,     forced_next;
    logic                     pin_reg,        pin_next;
    logic [7:0]               reject_reg,     reject_next;
    logic                     accepted;

    logic                     out_valid_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;
    logic                     out_pin_reg;
    logic                     out_heat_reg;
    logic                     out_forced_reg;
    logic                     out_accepted_reg;
    logic [7:0]               out_errors_reg;

    logic [REM_W:0]           rem_sum;
    logic                     carry;
    logic [REM_W:0]           rem_adj;
    logic signed [SUM_W-1:0]  quot_sum;
    logic [CNT_W:0]           cnt_inc;
    logic                     round_up;
    logic signed [21:0]       quot_round;
    logic [31:0]              elapsed;
    logic                     fresh;
    logic signed [TEMP_W-1:0] ctrl_temp;
    logic [8:0]               setpoint;
    logic signed [17:0]       sp_ext;
    logic signed [17:0]       ctrl_ext;
    logic signed [17:0]       delta;
    logic signed [17:0]       neg_hyst;

    assign advance = !out_valid_reg || result.ready;
    assign fire    = prep_valid && advance;

    always_comb
    begin
        // floor remainder/quotient accumulation of the running sum
        rem_sum    = {1'b0, rem_reg} + {1'b0, prep.sample_r};
        carry      = rem_sum >= (REM_W+1)'(AVERAGE_LENGTH);
        rem_adj    = carry ? rem_sum - (REM_W+1)'(AVERAGE_LENGTH) : rem_sum;
        quot_sum   = quot_reg + {{(SUM_W-QS_W){prep.sample_q[QS_W-1]}}, prep.sample_q}
                   + SUM_W'(carry);
        cnt_inc    = {1'b0, cnt_reg} + (CNT_W+1)'(1);
        // negative sum: floor to truncation, a remainder rounds toward zero; else round up from ROUND_LIMIT
        round_up   = quot_sum[SUM_W-1] ? (rem_adj != '0) : (rem_adj[REM_W-1:0] >= ROUND_LIMIT);
        quot_round = {quot_sum[SUM_W-1], quot_sum} + 22'(round_up);

        elapsed    = prep.now_ms - ext_stamp_reg;
        fresh      = ext_fresh_reg && (elapsed < cfg.external_timeout);
        ctrl_temp  = (fresh && (ext_temp_reg > avg_reg)) ? ext_temp_reg : avg_reg;
        setpoint   = prep.sp_sel ? cfg.setpoint_one : cfg.setpoint_zero;
        sp_ext     = {9'b0, setpoint};
        ctrl_ext   = {{2{ctrl_temp[15]}}, ctrl_temp};
        delta      = sp_ext - ctrl_ext;
        neg_hyst   = -$signed({10'b0, cfg.hysteresis});

        avg_next       = avg_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        ext_temp_next  = ext_temp_reg;
        ext_stamp_next = ext_stamp_reg;
        ext_fresh_next = ext_fresh_reg;
        no_demand_next = no_demand_reg;
        forced_next    = forced_reg;
        pin_next       = pin_reg;
        reject_next    = reject_reg;
        accepted       = 1'b0;

        case (prep.mode)
            MODE_SAMPLE:
            begin
                if (!prep.sample_ok)
                begin
                    reject_next = reject_reg + 8'd1;
                end
                else
                begin
                    quot_next = quot_sum;
                    rem_next  = rem_adj[REM_W-1:0];
                    cnt_next  = cnt_inc[CNT_W-1:0];
                    if (first_reg)
                    begin
                        avg_next   = prep.sample;
                        first_next = 1'b0;
                    end
                    if (cnt_inc >= (CNT_W+1)'(AVERAGE_LENGTH))
                    begin
                        avg_next  = sat16(quot_round);
                        quot_next = '0;
                        rem_next  = '0;
                        cnt_next  = '0;
                    end
                end
            end
            MODE_EXTERNAL:
            begin
                ext_temp_next  = prep.temperature;
                ext_stamp_next = prep.now_ms;
                ext_fresh_next = 1'b1;
            end
            MODE_CONTROL:
            begin
                if (!fresh)
                begin
                    ext_fresh_next = 1'b0;
                end
                if ((delta >= 18'sd1) && no_demand_reg)
                begin
                    no_demand_next = 1'b0;
                end
                else if ((delta <= neg_hyst) && !no_demand_reg)
                begin
                    no_demand_next = 1'b1;
                    forced_next    = 1'b0;
                end
                if (no_demand_next)
                begin
                    forced_next = 1'b0;
                end
                pin_next = no_demand_next ^ cfg.invert_output;
            end
            default:
            begin
                if (delta >= -18'sd1)
                begin
                    no_demand_next = 1'b0;
                    forced_next    = 1'b1;
                    accepted       = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg       <= AVG_RESET;
            quot_reg      <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            first_reg     <= 1'b1;
            ext_temp_reg  <= '0;
            ext_stamp_reg <= '0;
            ext_fresh_reg <= 1'b0;
            no_demand_reg <= 1'b1;
            forced_reg    <= 1'b0;
            pin_reg       <= 1'b1;
            reject_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                avg_reg       <= avg_next;
                quot_reg      <= quot_next;
                rem_reg       <= rem_next;
                cnt_reg       <= cnt_next;
                first_reg     <= first_next;
                ext_temp_reg  <= ext_temp_next;
                ext_stamp_reg <= ext_stamp_next;
                ext_fresh_reg <= ext_fresh_next;
                no_demand_reg <= no_demand_next;
                forced_reg    <= forced_next;
                pin_reg       <= pin_next;
                reject_reg    <= reject_next;
            end
            if (advance)
            begin
                out_valid_reg <= prep_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_temp_reg     <= avg_next;
            out_pin_reg      <= pin_next;
            out_heat_reg     <= (cfg.boiler_control || forced_next) ? no_demand_next : 1'b1;
            out_forced_reg   <= forced_next;
            out_accepted_reg <= accepted;
            out_errors_reg   <= reject_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.measured_temp  = out_temp_reg;
    assign result.heater_pin     = out_pin_reg;
    assign result.heat_reported  = out_heat_reg;
    assign result.forced_active  = out_forced_reg;
    assign result.force_accepted = out_accepted_reg;
    assign result.reject_total   = out_errors_reg;

endmodule

// File: design/rtwa_checker.sv
// ----------------------------------------------------------------------------
// rtwa_checker
// Port-level checks on the thermostat result channel.
// ----------------------------------------------------------------------------
module rtwa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [15:0] out_temp,
    input logic       out_pin,
    input logic       out_heat,
    input logic       out_forced,
    input logic       out_accepted,
    input logic [7:0] out_errors
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_temp) && $stable(out_pin)
            && $stable(out_heat) && $stable(out_forced) && $stable(out_accepted)
            && $stable(out_errors))
        else $error("result changed while stalled");

    // a successful force leaves heating forced
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_accepted |-> out_forced)
        else $error("force accepted without forced flag");

    // forced heating always means demand, reported as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_forced |-> !out_heat)
        else $error("forced heating reported as no demand");

    // a result appearing on an empty output comes from a request taken by the input register and passed straight on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a request");

endmodule

bind room_thermostat_with_averaging_core rtwa_checker u_rtwa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (item.valid),
    .in_ready     (item.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_temp     (result.measured_temp),
    .out_pin      (result.heater_pin),
    .out_heat     (result.heat_reported),
    .out_forced   (result.forced_active),
    .out_accepted (result.force_accepted),
    .out_errors   (result.reject_total)
);

// File: test/thermostat_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thermostat_checker
// Watches the request and result channels and the register port of the room
// thermostat. It keeps its own copy of the registers and the thermostat
// state, works out the result of every accepted request, and compares each
// result the block returns with the oldest one still waiting.
// ----------------------------------------------------------------------------
module thermostat_checker #(
    parameter int AVERAGE_LENGTH = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rtwa_in_if                          item,
    rtwa_out_if                         result,
    input  logic                        cfg_we,
    input  logic [rtwa_pkg::IDX_W-1:0]  cfg_index,
    input  logic [rtwa_pkg::DATA_W-1:0] cfg_data,
    output int                          fail_count,
    output int                          in_flight
);
    import rtwa_pkg::*;

    typedef struct packed {
        logic signed [TEMP_W-1:0] measured_temp;
        logic                     heater_pin;
        logic                     heat_reported;
        logic                     forced_active;
        logic                     force_accepted;
        logic [7:0]               reject_total;
    } reading_t;

    cfg_t        regs;
    int          avg_temp;
    int          sample_sum;
    int          sample_count;
    int          ext_temp;
    logic [31:0] ext_stamp;
    logic        first_pending;
    logic        ext_fresh;
    logic        no_demand;
    logic        forced;
    logic        pin;
    logic [7:0]  reject_count;

    reading_t    pending_readings[$];

    function automatic int clamp16(input int v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    task automatic reset_thermostat();
        regs.hour_schedule    = 24'd4194240;
        regs.setpoint_zero    = 9'd180;
        regs.setpoint_one     = 9'd210;
        regs.hysteresis       = 8'd4;
        regs.correction       = 8'sd0;
        regs.invert_output    = 1'b0;
        regs.boiler_control   = 1'b1;
        regs.external_timeout = 32'd600000;
        avg_temp      = int'(AVG_RESET);
        sample_sum    = 0;
        sample_count  = 0;
        first_pending = 1'b1;
        ext_temp      = 0;
        ext_stamp     = '0;
        ext_fresh     = 1'b0;
        no_demand     = 1'b1;
        forced        = 1'b0;
        pin           = 1'b1;
        reject_count  = '0;
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        case (idx)
            REG_HOUR_SCHEDULE:    regs.hour_schedule    = data[23:0];
            REG_SETPOINT_ZERO:    regs.setpoint_zero    = data[8:0];
            REG_SETPOINT_ONE:     regs.setpoint_one     = data[8:0];
            REG_HYSTERESIS:       regs.hysteresis       = data[7:0];
            REG_CORRECTION:       regs.correction       = data[7:0];
            REG_INVERT_OUTPUT:    regs.invert_output    = data[0];
            REG_BOILER_CONTROL:   regs.boiler_control   = data[0];
            REG_EXTERNAL_TIMEOUT: regs.external_timeout = data;
            default: ;
        endcase
    endtask

    // Apply one request to the thermostat state and return the reading it yields.
    task automatic advance_thermostat(
        input  logic [1:0]               mode,
        input  logic signed [TEMP_W-1:0] temp,
        input  logic                     ok,
        input  logic [4:0]               hour,
        input  logic                     fsel,
        input  logic [31:0]              now,
        output reading_t                 r
    );
        int          t;
        int          offset;
        int          corrected;
        int          quotient;
        int          remainder;
        int          target;
        int          ctl;
        int          delta;
        logic [31:0] age;
        logic        sel;
        logic        fresh;
        logic        accepted;
        t        = temp;
        offset   = $signed(regs.correction);
        accepted = 1'b0;
        age      = now - ext_stamp;
        fresh    = ext_fresh && (age < regs.external_timeout);
        ctl      = (fresh && ext_temp > avg_temp) ? ext_temp : avg_temp;
        case (mode_t'(mode))
            MODE_SAMPLE:
            begin
                if (!ok || t == 0 || t < int'(REJECT_FLOOR))
                begin
                    reject_count = reject_count + 8'd1;
                end
                else
                begin
                    corrected  = clamp16(t + offset);
                    sample_sum = sample_sum + corrected;
                    if (first_pending)
                    begin
                        avg_temp      = corrected;
                        first_pending = 1'b0;
                    end
                    sample_count++;
                    if (sample_count >= AVERAGE_LENGTH)
                    begin
                        quotient  = sample_sum / AVERAGE_LENGTH;
                        remainder = sample_sum % AVERAGE_LENGTH;
                        if (remainder >= int'(ROUND_LIMIT))
                        begin
                            quotient++;
                        end
                        avg_temp     = clamp16(quotient);
                        sample_count = 0;
                        sample_sum   = 0;
                    end
                end
            end
            MODE_EXTERNAL:
            begin
                ext_temp  = t;
                ext_stamp = now;
                ext_fresh = 1'b1;
            end
            MODE_CONTROL:
            begin
                // hours past 23 read a zero schedule bit
                sel    = (hour < 5'd24) ? regs.hour_schedule[hour] : 1'b0;
                target = sel ? int'(regs.setpoint_one) : int'(regs.setpoint_zero);
                if (!fresh)
                begin
                    ext_fresh = 1'b0;
                end
                delta = target - ctl;
                if (delta >= 1 && no_demand)
                begin
                    no_demand = 1'b0;
                end
                else if (delta <= -int'(regs.hysteresis) && !no_demand)
                begin
                    no_demand = 1'b1;
                    forced    = 1'b0;
                end
                if (no_demand)
                begin
                    forced = 1'b0;
                end
                pin = no_demand ^ regs.invert_output;
            end
            default:
            begin
                target = fsel ? int'(regs.setpoint_one) : int'(regs.setpoint_zero);
                if (target - ctl >= -1)
                begin
                    no_demand = 1'b0;
                    forced    = 1'b1;
                    accepted  = 1'b1;
                end
            end
        endcase
        r.measured_temp  = avg_temp[TEMP_W-1:0];
        r.heater_pin     = pin;
        r.heat_reported  = (regs.boiler_control || forced) ? no_demand : 1'b1;
        r.forced_active  = forced;
        r.force_accepted = accepted;
        r.reject_total   = reject_count;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        reading_t got;
        if (!rst_n)
        begin
            reset_thermostat();
            pending_readings.delete();
            fail_count = 0;
            in_flight  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                write_register(cfg_index, cfg_data);
            end
            // compare before the new request is queued: a result never belongs to it
            if (result.valid && result.ready)
            begin
                got.measured_temp  = result.measured_temp;
                got.heater_pin     = result.heater_pin;
                got.heat_reported  = result.heat_reported;
                got.forced_active  = result.forced_active;
                got.force_accepted = result.force_accepted;
                got.reject_total   = result.reject_total;
                if (pending_readings.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("%0t: result with no request outstanding: temp %0d",
                                 $realtime, got.measured_temp);
                    end
                    fail_count++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (got.measured_temp !== want.measured_temp
                        || got.heater_pin !== want.heater_pin
                        || got.heat_reported !== want.heat_reported
                        || got.forced_active !== want.forced_active
                        || got.force_accepted !== want.force_accepted
                        || got.reject_total !== want.reject_total)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: mismatch temp %0d/%0d pin %b/%b rep %b/%b",
                                     $realtime, want.measured_temp, got.measured_temp,
                                     want.heater_pin, got.heater_pin,
                                     want.heat_reported, got.heat_reported);
                            $display("    forced %b/%b accepted %b/%b errors %0d/%0d",
                                     want.forced_active, got.forced_active,
                                     want.force_accepted, got.force_accepted,
                                     want.reject_total, got.reject_total);
                        end
                        fail_count++;
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                advance_thermostat(item.mode, item.temperature, item.sample_valid,
                                   item.hour, item.force_select, item.now_ms, want);
                pending_readings.push_back(want);
            end
            in_flight = pending_readings.size();
        end
    end

endmodule

// File: test/room_thermostat_with_averaging_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// room_thermostat_with_averaging_core_tb
// Drives the thermostat core with a directed set of requests and then with
// random phases under changing register settings, with random gaps on both
// channels, one long result stall and a drain before every register update.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module room_thermostat_with_averaging_core_tb;
    import rtwa_pkg::*;

    localparam int AVG_LEN       = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 235;
    localparam int HOLD_CYCLES   = 60;
    localparam int CYCLE_LIMIT   = 400000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0] cfg_data;
    int                fail_count;
    int                in_flight;
    int                idle_style;
    logic              hold_off;
    logic [31:0]       clock_ms;
    int                cycles;

    rtwa_in_if  req_ch ();
    rtwa_out_if res_ch ();

    room_thermostat_with_averaging_core #(
        .AVERAGE_LENGTH (AVG_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (req_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    thermostat_checker #(
        .AVERAGE_LENGTH (AVG_LEN)
    ) thermo_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (req_ch),
        .result     (res_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .in_flight  (in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // style 0: full random gaps, 1: back to back, 2: mostly back to back
    function automatic int draw_gap();
        if (idle_style == 1)
        begin
            return 0;
        end
        if (idle_style == 2)
        begin
            return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // result side
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_gap();
            if (hold_off)
            begin
                hold_off = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
            @(negedge clk);
        end
    end

    task automatic send_request(
        input mode_t                    mode,
        input logic signed [TEMP_W-1:0] temp,
        input logic                     ok,
        input logic [4:0]               hour,
        input logic                     fsel,
        input logic [31:0]              now
    );
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.mode         <= mode;
        req_ch.temperature  <= temp;
        req_ch.sample_valid <= ok;
        req_ch.hour         <= hour;
        req_ch.force_select <= fsel;
        req_ch.now_ms       <= now;
        req_ch.valid        <= 1'b1;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        @(negedge clk);
    endtask

    // Drop valid and hold until every request has returned its result.
    task automatic drain();
        req_ch.valid <= 1'b0;
        wait (in_flight == 0);
        @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic configure(
        input logic [23:0] schedule,
        input logic [8:0]  sp_zero,
        input logic [8:0]  sp_one,
        input logic [7:0]  hyst,
        input logic [7:0]  corr,
        input logic        inv,
        input logic        boiler,
        input logic [31:0] timeout
    );
        write_reg(REG_HOUR_SCHEDULE, {8'd0, schedule});
        write_reg(REG_SETPOINT_ZERO, {23'd0, sp_zero});
        write_reg(REG_SETPOINT_ONE, {23'd0, sp_one});
        write_reg(REG_HYSTERESIS, {24'd0, hyst});
        write_reg(REG_CORRECTION, {24'd0, corr});
        write_reg(REG_INVERT_OUTPUT, {31'd0, inv});
        write_reg(REG_BOILER_CONTROL, {31'd0, boiler});
        write_reg(REG_EXTERNAL_TIMEOUT, timeout);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random();
        int                       pick;
        logic signed [TEMP_W-1:0] temp;
        logic                     ok;
        logic [4:0]               hour;
        mode_t                    mode;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0)
        begin
            clock_ms = $urandom;
        end
        else
        begin
            clock_ms = clock_ms + $urandom_range(0, 2000);
        end
        case ($urandom_range(0, 9))
            0: temp = TEMP_W'($urandom);
            1:
            begin
                case ($urandom_range(0, 4))
                    0: temp = '0;
                    1: temp = REJECT_FLOOR;
                    2: temp = REJECT_FLOOR - 16'sd1;
                    3: temp = 16'sd1;
                    default: temp = -16'sd1;
                endcase
            end
            default: temp = TEMP_W'($urandom_range(50, 450));
        endcase
        ok   = ($urandom_range(0, 9) != 0);
        hour = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                           : 5'($urandom_range(0, 23));
        if (pick < 45)
        begin
            mode = MODE_SAMPLE;
        end
        else if (pick < 60)
        begin
            mode = MODE_EXTERNAL;
        end
        else if (pick < 85)
        begin
            mode = MODE_CONTROL;
        end
        else
        begin
            mode = MODE_FORCE;
        end
        send_request(mode, temp, ok, hour, 1'($urandom_range(0, 1)), clock_ms);
    endtask

    initial
    begin
        logic [31:0] timeout;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = '0;
        req_ch.temperature  = '0;
        req_ch.sample_valid = 1'b0;
        req_ch.hour         = '0;
        req_ch.force_select = 1'b0;
        req_ch.now_ms       = '0;
        idle_style          = 0;
        hold_off            = 1'b0;
        clock_ms            = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: rejects, first sample, demand, stale and wrapped external time
        send_request(MODE_CONTROL, 16'sd0, 1'b1, 5'd3, 1'b0, 32'd0);
        send_request(MODE_FORCE, 16'sd0, 1'b1, 5'd0, 1'b1, 32'd0);
        send_request(MODE_SAMPLE, 16'sd200, 1'b0, 5'd0, 1'b0, 32'd0);
        send_request(MODE_SAMPLE, 16'sd0, 1'b1, 5'd0, 1'b0, 32'd0);
        send_request(MODE_SAMPLE, REJECT_FLOOR - 16'sd1, 1'b1, 5'd0, 1'b0, 32'd0);
        send_request(MODE_SAMPLE, 16'sh8000, 1'b1, 5'd31, 1'b1, 32'd0);
        send_request(MODE_SAMPLE, REJECT_FLOOR, 1'b1, 5'd0, 1'b0, 32'd0);
        send_request(MODE_CONTROL, 16'sd0, 1'b1, 5'd12, 1'b0, 32'd100);
        send_request(MODE_FORCE, 16'sd0, 1'b1, 5'd0, 1'b0, 32'd200);
        send_request(MODE_EXTERNAL, 16'sh7FFF, 1'b1, 5'd0, 1'b0, 32'd1000);
        send_request(MODE_CONTROL, 16'sd0, 1'b1, 5'd23, 1'b0, 32'd2000);
        send_request(MODE_CONTROL, 16'sd0, 1'b1, 5'd31, 1'b0, 32'd700000);
        send_request(MODE_EXTERNAL, 16'sh8000, 1'b1, 5'd0, 1'b0, 32'hFFFF_FF00);
        send_request(MODE_CONTROL, 16'sd0, 1'b1, 5'd7, 1'b0, 32'h0000_0010);
        send_request(MODE_FORCE, 16'sd0, 1'b1, 5'd0, 1'b1, 32'h0000_0020);
        send_request(MODE_SAMPLE, 16'sh7FFF, 1'b1, 5'd31, 1'b1, 32'hFFFF_FFFF);
        send_request(MODE_SAMPLE, 16'sd150, 1'b1, 5'd0, 1'b0, 32'd0);
        drain();

        // high correction saturates, a zero timeout is never fresh
        configure(24'hFFFFFF, 9'd0, 9'd511, 8'd255, 8'h7F, 1'b1, 1'b0, 32'd0);
        send_request(MODE_SAMPLE, 16'sh7FFF, 1'b1, 5'd0, 1'b0, 32'd0);
        send_request(MODE_SAMPLE, 16'sd32700, 1'b1, 5'd0, 1'b0, 32'd0);
        send_request(MODE_EXTERNAL, 16'sd400, 1'b1, 5'd0, 1'b0, 32'd5);
        send_request(MODE_CONTROL, 16'sd0, 1'b1, 5'd0, 1'b0, 32'd5);
        send_request(MODE_FORCE, 16'sd0, 1'b1, 5'd0, 1'b0, 32'd5);
        send_request(MODE_CONTROL, 16'sd0, 1'b1, 5'd24, 1'b0, 32'd6);
        drain();

        configure(24'h000000, 9'd100, 9'd400, 8'd0, 8'h80, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_request(MODE_SAMPLE, -16'sd600, 1'b1, 5'd0, 1'b0, 32'd0);
        send_request(MODE_SAMPLE, 16'sd1, 1'b1, 5'd0, 1'b0, 32'd0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            idle_style = p % 3;
            case ($urandom_range(0, 3))
                0: timeout = 32'd3000;
                1: timeout = 32'd20000;
                2: timeout = 32'd600000;
                default: timeout = $urandom;
            endcase
            case (p)
                1: configure(24'h000000, 9'd100, 9'd400, 8'd0, 8'h80, 1'b0, 1'b1,
                             32'hFFFF_FFFF);
                3: configure(24'hFFFFFF, 9'd0, 9'd511, 8'd255, 8'h7F, 1'b1, 1'b0, 32'd0);
                default: configure(24'($urandom), 9'($urandom_range(100, 400)),
                                   9'($urandom_range(100, 400)), 8'($urandom_range(0, 20)),
                                   8'($urandom), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), timeout);
            endcase
            if (p == 2)
            begin
                // stall results for a long stretch while requests keep coming
                idle_style = 1;
                hold_off   = 1'b1;
            end
            repeat (PHASE_ITEMS) send_random();
            drain();
        end

        repeat (10) @(negedge clk);
        if (fail_count == 0 && in_flight == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: room_thermostat_with_averaging_core.f
design/rtwa_pkg.sv
design/rtwa_if.sv
design/rtwa_cfg.sv
design/rtwa_prep.sv
design/rtwa_core.sv
design/room_thermostat_with_averaging_core.sv
design/rtwa_checker.sv
test/thermostat_checker.sv
test/room_thermostat_with_averaging_core_tb.sv
